/* rtl/rpfa_pkg.sv */
package rpfa_pkg;

  localparam int NumPagesDef   = 1024;
  localparam int PageBitsDef   = 12;
  localparam int CountWidthDef = 16;
  localparam int CfgWidth      = 11;
  localparam int CfgIdxWidth   = 3;

  // register indexes
  localparam logic [CfgIdxWidth-1:0] RegRamPages    = 3'd0;
  localparam logic [CfgIdxWidth-1:0] RegHoleStart   = 3'd1;
  localparam logic [CfgIdxWidth-1:0] RegHoleEnd     = 3'd2;
  localparam logic [CfgIdxWidth-1:0] RegKernelStart = 3'd3;
  localparam logic [CfgIdxWidth-1:0] RegKernelEnd   = 3'd4;

  // request modes
  localparam logic [2:0] ModeInit     = 3'd0;
  localparam logic [2:0] ModeAlloc    = 3'd1;
  localparam logic [2:0] ModeRef      = 3'd2;
  localparam logic [2:0] ModeUnref    = 3'd3;
  localparam logic [2:0] ModeReadTag  = 3'd4;
  localparam logic [2:0] ModeWriteTag = 3'd5;

  // status codes
  localparam logic [2:0] StOk       = 3'd0;
  localparam logic [2:0] StBadAddr  = 3'd1;
  localparam logic [2:0] StNoFree   = 3'd2;
  localparam logic [2:0] StNotRef   = 3'd3;
  localparam logic [2:0] StInitFail = 3'd4;
  localparam logic [2:0] StSat      = 3'd5;

  typedef struct packed {
    logic [2:0]  mode;
    logic [31:0] page_address;
    logic [31:0] tag_value;
  } req_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [31:0] result_address;
    logic        was_shared;
    logic        became_free;
    logic [31:0] tag_out;
    logic [10:0] used_pages;
    logic [10:0] total_pages;
    logic [31:0] kernel_low_address;
    logic [31:0] kernel_high_address;
  } rsp_t;

endpackage

/* rtl/rpfa_ram.sv */
module rpfa_ram #(
  parameter int Width = 8,
  parameter int Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

/* rtl/refcounted_page_frame_allocator.sv */
// Page frame allocator with per-page reference counts, tags and a circular
// doubly linked free list, all held in single-port-read synchronous RAMs.
// The done strobe follows S_DEC and S_DONE for a bad address; S_DEC, S_RD, S_EVAL and S_DONE
// for a tag or plain count change. Allocate and reference of a free page unlink via S_UL_*
// (no link writes for the last free page); release pushes via S_PH_*. Init: clear sweep, then
// S_PINIT per page, free ones pushed via S_PH_*. One request at a time; reset empties the list, sweeps RAMs clear.
module refcounted_page_frame_allocator #(
  parameter int NumPages   = rpfa_pkg::NumPagesDef,
  parameter int PageBits   = rpfa_pkg::PageBitsDef,
  parameter int CountWidth = rpfa_pkg::CountWidthDef
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               start,
  output logic                               busy,
  input  rpfa_pkg::req_t                     req_i,
  output logic                               done_o,
  output rpfa_pkg::rsp_t                     rsp_o,
  input  logic                               cfg_we_i,
  input  logic [rpfa_pkg::CfgIdxWidth-1:0]   cfg_idx_i,
  input  logic [rpfa_pkg::CfgWidth-1:0]      cfg_data_i
);

  localparam int Aw = $clog2(NumPages);
  localparam int Cw = rpfa_pkg::CfgWidth;
  // page counter wide enough for NumPages and for config values
  localparam int Pw = (Aw + 1 > Cw) ? Aw + 1 : Cw;

  typedef enum logic [4:0] {
    S_IDLE, S_CLR, S_PINIT, S_DEC, S_RD, S_EVAL,
    S_UL_RDN, S_UL_RDN2, S_UL_WQ, S_UL_WN,
    S_PH_RD, S_PH_RD2, S_PH_WP, S_PH_WT, S_PH_WH,
    S_DONE
  } state_e;

  state_e state_q;

  // configuration
  logic [Cw-1:0] ram_pages_q, hole_s_q, hole_e_q, kern_s_q, kern_e_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ram_pages_q <= Cw'(1024);
      hole_s_q    <= Cw'(160);
      hole_e_q    <= Cw'(256);
      kern_s_q    <= Cw'(256);
      kern_e_q    <= Cw'(512);
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        rpfa_pkg::RegRamPages:    ram_pages_q <= cfg_data_i;
        rpfa_pkg::RegHoleStart:   hole_s_q    <= cfg_data_i;
        rpfa_pkg::RegHoleEnd:     hole_e_q    <= cfg_data_i;
        rpfa_pkg::RegKernelStart: kern_s_q    <= cfg_data_i;
        rpfa_pkg::RegKernelEnd:   kern_e_q    <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // memories: count, tag, next, prev
  logic            cnt_we, tag_we, nxt_we, prv_we;
  logic [Aw-1:0]   cnt_wa, tag_wa, nxt_wa, prv_wa;
  logic [Aw-1:0]   cnt_ra, tag_ra, nxt_ra, prv_ra;
  logic [CountWidth-1:0] cnt_wd, cnt_rd;
  logic [31:0]     tag_wd, tag_rd;
  logic [Aw-1:0]   nxt_wd, nxt_rd, prv_wd, prv_rd;

  rpfa_ram #(.Width(CountWidth), .Depth(NumPages)) u_cnt (
    .clk_i, .we_i(cnt_we), .waddr_i(cnt_wa), .wdata_i(cnt_wd),
    .raddr_i(cnt_ra), .rdata_o(cnt_rd));
  rpfa_ram #(.Width(32), .Depth(NumPages)) u_tag (
    .clk_i, .we_i(tag_we), .waddr_i(tag_wa), .wdata_i(tag_wd),
    .raddr_i(tag_ra), .rdata_o(tag_rd));
  rpfa_ram #(.Width(Aw), .Depth(NumPages)) u_nxt (
    .clk_i, .we_i(nxt_we), .waddr_i(nxt_wa), .wdata_i(nxt_wd),
    .raddr_i(nxt_ra), .rdata_o(nxt_rd));
  rpfa_ram #(.Width(Aw), .Depth(NumPages)) u_prv (
    .clk_i, .we_i(prv_we), .waddr_i(prv_wa), .wdata_i(prv_wd),
    .raddr_i(prv_ra), .rdata_o(prv_rd));

  // control registers
  rpfa_pkg::req_t req_q;
  logic [Pw-1:0]  ptr_q;       // sweep pointer
  logic [Pw-1:0]  top_q;       // pages managed
  logic [Aw-1:0]  head_q;
  logic           hvalid_q;
  logic [Cw-1:0]  used_q, total_q;
  logic [Aw-1:0]  pg_q;        // page under work
  logic [Aw-1:0]  n_q, p_q;    // link neighbors
  logic           clr_pend_q;  // initial clear after reset
  logic           init_mode_q; // push phase belongs to init
  rpfa_pkg::rsp_t rsp_q;
  logic           done_q;
  logic [CountWidth-1:0] cnt_upd_q;    // count write-back, written in the cycle after evaluation or alloc decode
  logic                  cnt_upd_we_q;

  // managed page count
  logic [Pw-1:0] n_pages;
  assign n_pages = (Pw'(ram_pages_q) < Pw'(NumPages)) ? Pw'(ram_pages_q) : Pw'(NumPages);

  // address decode
  logic [31:0] addr;
  logic [31:0] pidx_w;
  logic        addr_ok;
  assign addr   = req_q.page_address;
  assign pidx_w = addr >> PageBits;
  assign addr_ok = (addr[PageBits-1:0] == '0) && (pidx_w != 32'd0) &&
                   (pidx_w < 32'(top_q)) && (pidx_w < 32'(NumPages));

  // init classification of ptr_q
  logic [Pw-1:0] hs, he, ks, ke;
  logic          is_used;
  assign hs = Pw'(hole_s_q);
  assign he = Pw'(hole_e_q);
  assign ks = Pw'(kern_s_q);
  assign ke = Pw'(kern_e_q);
  always_comb begin
    if (ptr_q < hs)                     is_used = 1'b0;
    else if (ptr_q < he)                is_used = 1'b1;
    else if (ptr_q < ks)                is_used = 1'b0;
    else if (ptr_q < ke)                is_used = 1'b1;
    else                                is_used = 1'b0;
  end

  function automatic logic [31:0] paddr(input logic [Pw-1:0] p);
    logic [63:0] w;
    w = 64'(p) << PageBits;
    return w[31:0];
  endfunction

  assign busy   = (state_q != S_IDLE) || clr_pend_q;
  assign done_o = done_q;
  assign rsp_o  = rsp_q;

  // memory port control (combinational from state)
  always_comb begin
    cnt_we = 1'b0; tag_we = 1'b0; nxt_we = 1'b0; prv_we = 1'b0;
    cnt_wa = pg_q; tag_wa = pg_q; nxt_wa = pg_q; prv_wa = pg_q;
    cnt_wd = '0;   tag_wd = '0;   nxt_wd = '0;   prv_wd = '0;
    cnt_ra = pg_q; tag_ra = pg_q; nxt_ra = pg_q; prv_ra = pg_q;
    // pending count update lands in a state that leaves the count RAM idle
    if (cnt_upd_we_q) begin
      cnt_we = 1'b1; cnt_wd = cnt_upd_q;
    end
    case (state_q)
      S_CLR: begin
        cnt_we = 1'b1; tag_we = 1'b1;
        cnt_wa = ptr_q[Aw-1:0]; tag_wa = ptr_q[Aw-1:0];
      end
      S_PINIT: begin
        if (ptr_q != '0 && is_used) begin
          cnt_we = 1'b1; cnt_wa = ptr_q[Aw-1:0]; cnt_wd = CountWidth'(1);
        end
      end
      S_DEC: begin
        cnt_ra = pidx_w[Aw-1:0]; tag_ra = pidx_w[Aw-1:0];
      end
      S_EVAL: begin
        if (req_q.mode == rpfa_pkg::ModeWriteTag) begin
          tag_we = 1'b1; tag_wd = req_q.tag_value;
        end
      end
      S_UL_WQ: begin
        nxt_we = 1'b1; nxt_wa = p_q; nxt_wd = n_q;
      end
      S_UL_WN: begin
        prv_we = 1'b1; prv_wa = n_q; prv_wd = p_q;
      end
      S_PH_RD: prv_ra = head_q;
      S_PH_WP: begin
        nxt_we = 1'b1; prv_we = 1'b1;
        nxt_wd = hvalid_q ? head_q : pg_q;
        prv_wd = hvalid_q ? p_q : pg_q;
      end
      S_PH_WT: begin
        nxt_we = 1'b1; nxt_wa = p_q; nxt_wd = pg_q;
        prv_we = 1'b1; prv_wa = head_q; prv_wd = pg_q;
      end
      default: ;
    endcase
  end

  // sequencer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLR;
      clr_pend_q  <= 1'b1;
      ptr_q       <= '0;
      top_q       <= '0;
      head_q      <= '0;
      hvalid_q    <= 1'b0;
      used_q      <= '0;
      total_q     <= '0;
      done_q      <= 1'b0;
      init_mode_q <= 1'b0;
      pg_q        <= '0;
      n_q         <= '0;
      p_q         <= '0;
      req_q       <= '0;
      rsp_q       <= '0;
    end else begin
      done_q <= 1'b0;
      case (state_q)
        S_IDLE: begin
          if (start) begin
            req_q <= req_i;
            rsp_q <= '0;
            if (req_i.mode == rpfa_pkg::ModeInit) begin
              rsp_q.kernel_low_address  <= paddr(Pw'(kern_s_q));
              rsp_q.kernel_high_address <= paddr(Pw'(kern_e_q));
              ptr_q    <= '0;
              top_q    <= '0;
              hvalid_q <= 1'b0;
              head_q   <= '0;
              used_q   <= '0;
              total_q  <= '0;
              state_q  <= S_CLR;
            end else begin
              state_q <= S_DEC;
            end
          end
        end
        // clear sweep over every entry
        S_CLR: begin
          if (ptr_q == Pw'(NumPages - 1)) begin
            ptr_q <= '0;
            if (clr_pend_q) begin
              clr_pend_q <= 1'b0;
              state_q    <= S_IDLE;
            end else if (Pw'(kern_e_q) > n_pages) begin
              rsp_q.status <= rpfa_pkg::StInitFail;
              state_q      <= S_DONE;
            end else begin
              top_q   <= n_pages;
              state_q <= (n_pages == '0) ? S_DONE : S_PINIT;
            end
          end else begin
            ptr_q <= ptr_q + 1'b1;
          end
        end
        // classify one page
        S_PINIT: begin
          total_q <= total_q + 1'b1;
          pg_q    <= ptr_q[Aw-1:0];
          init_mode_q <= 1'b1;
          if (ptr_q == '0) begin
            ptr_q   <= ptr_q + 1'b1;
            state_q <= (ptr_q + 1'b1 == top_q) ? S_DONE : S_PINIT;
          end else if (is_used) begin
            used_q  <= used_q + 1'b1;
            ptr_q   <= ptr_q + 1'b1;
            state_q <= (ptr_q + 1'b1 == top_q) ? S_DONE : S_PINIT;
          end else begin
            state_q <= S_PH_RD;
          end
        end
        S_DEC: begin
          init_mode_q <= 1'b0;
          pg_q        <= pidx_w[Aw-1:0];
          case (req_q.mode)
            rpfa_pkg::ModeAlloc: begin
              if (!hvalid_q) begin
                rsp_q.status <= rpfa_pkg::StNoFree;
                state_q      <= S_DONE;
              end else begin
                pg_q    <= head_q;
                rsp_q.result_address <= paddr(Pw'(head_q));
                used_q  <= used_q + 1'b1;
                state_q <= S_UL_RDN;
              end
            end
            rpfa_pkg::ModeRef, rpfa_pkg::ModeUnref, rpfa_pkg::ModeReadTag,
            rpfa_pkg::ModeWriteTag: begin
              if (!addr_ok) begin
                rsp_q.status <= rpfa_pkg::StBadAddr;
                state_q      <= S_DONE;
              end else begin
                state_q <= S_RD;
              end
            end
            default: state_q <= S_DONE;
          endcase
        end
        S_RD: state_q <= S_EVAL;
        S_EVAL: begin
          state_q <= S_DONE;
          case (req_q.mode)
            rpfa_pkg::ModeReadTag: rsp_q.tag_out <= tag_rd;
            rpfa_pkg::ModeRef: begin
              if (cnt_rd == {CountWidth{1'b1}}) begin
                rsp_q.status     <= rpfa_pkg::StSat;
                rsp_q.was_shared <= 1'b1;
              end else if (cnt_rd == '0) begin
                used_q  <= used_q + 1'b1;
                state_q <= S_UL_RDN;
              end else begin
                rsp_q.was_shared <= 1'b1;
              end
            end
            rpfa_pkg::ModeUnref: begin
              if (cnt_rd == '0) begin
                rsp_q.status <= rpfa_pkg::StNotRef;
              end else if (cnt_rd == CountWidth'(1)) begin
                if (used_q != '0) used_q <= used_q - 1'b1;
                rsp_q.became_free <= 1'b1;
                state_q <= S_PH_RD;
              end
            end
            default: ;
          endcase
        end
        // unlink pg_q: read next and prev
        S_UL_RDN: state_q <= S_UL_RDN2;
        S_UL_RDN2: begin
          n_q <= nxt_rd;
          p_q <= prv_rd;
          if (nxt_rd == pg_q) begin
            hvalid_q <= 1'b0;
            head_q   <= '0;
            state_q  <= S_DONE;
          end else begin
            if (head_q == pg_q) head_q <= nxt_rd;
            state_q <= S_UL_WQ;
          end
        end
        S_UL_WQ: state_q <= S_UL_WN;
        S_UL_WN: state_q <= S_DONE;
        // push pg_q at head: read tail
        S_PH_RD: state_q <= S_PH_RD2;
        S_PH_RD2: begin
          p_q     <= prv_rd;
          state_q <= S_PH_WP;
        end
        S_PH_WP: state_q <= hvalid_q ? S_PH_WT : S_PH_WH;
        S_PH_WT: state_q <= S_PH_WH;
        S_PH_WH: begin
          head_q   <= pg_q;
          hvalid_q <= 1'b1;
          if (init_mode_q) begin
            ptr_q   <= ptr_q + 1'b1;
            state_q <= (ptr_q + 1'b1 == top_q) ? S_DONE : S_PINIT;
          end else begin
            state_q <= S_DONE;
          end
        end
        S_DONE: begin
          done_q            <= 1'b1;
          rsp_q.used_pages  <= used_q;
          rsp_q.total_pages <= total_q;
          state_q           <= S_IDLE;
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  // count write-back for ref/unref/alloc, written at pg_q in the next cycle
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_upd_we_q <= 1'b0;
      cnt_upd_q    <= '0;
    end else begin
      cnt_upd_we_q <= 1'b0;
      if (state_q == S_EVAL && req_q.mode == rpfa_pkg::ModeRef &&
          cnt_rd != {CountWidth{1'b1}}) begin
        cnt_upd_we_q <= 1'b1;
        cnt_upd_q    <= cnt_rd + 1'b1;
      end else if (state_q == S_EVAL && req_q.mode == rpfa_pkg::ModeUnref &&
                   cnt_rd != '0) begin
        cnt_upd_we_q <= 1'b1;
        cnt_upd_q    <= cnt_rd - 1'b1;
      end else if (state_q == S_DEC && req_q.mode == rpfa_pkg::ModeAlloc && hvalid_q) begin
        cnt_upd_we_q <= 1'b1;
        cnt_upd_q    <= CountWidth'(1);
      end
    end
  end

endmodule
